### rtl/core/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and constants for the indexed min-heap queue
// Slot word layout, action and status codes, and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int IDX_W  = ADDR_W + 2;   // holds 2*slot+2
  localparam int KEY_W  = 32;
  localparam int ELEM_W = 10;
  localparam int ELEM_SPAN = 1 << ELEM_W;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    key_t  key;
    elem_t elem;
  } slot_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_PULL   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_PLACE,
    S_PULL_RT,
    S_PULL_MV,
    S_UPD_POS,
    S_UPD_SLOT,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top: addressable binary min-heap with key update
// Heap slots and element position table live in two synchronous RAMs;
// a sequencer walks sift-up / sift-down one level at a time.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------
//  in      | action, elem_index, key_time              | in_valid/in_ready
//  out     | status, out_time, out_index, fill_count   | out_valid/out_ready
//  cfg     | cfg_wdata (capacity_in_use)               | cfg_we, no wait
//
//  One word at a time. Add climbs a level per parent read and compare,
//  unless it starts at the root. Pull reads the root and the last slot,
//  then descends, reading both children per level, unless it empties.
//  Update reads the position, then the slot; a held element with a new key sifts.
//  Full add, empty pull and clear go straight to the result, which waits
//  in DONE while the output register is full; the next word can be taken
//  as the result appears. Reset idles, clears count and valid, caps at depth.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [imhq_pkg::ELEM_W-1:0] elem_index,
  input  wire logic [imhq_pkg::KEY_W-1:0]  key_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [imhq_pkg::KEY_W-1:0]       out_time,
  output logic [imhq_pkg::ELEM_W-1:0]      out_index,
  output logic [imhq_pkg::CNT_W-1:0]       fill_count,
  input  wire logic                        cfg_we,
  input  wire logic [imhq_pkg::CNT_W-1:0]  cfg_wdata
);

  imhq_pkg::state_t state, state_next;

  imhq_pkg::slot_t heap_mem [imhq_pkg::DEPTH];
  imhq_pkg::addr_t pos_mem  [imhq_pkg::ELEM_SPAN];

  imhq_pkg::slot_t heap_rd;
  imhq_pkg::addr_t pos_rd;

  // memory control
  logic            heap_re, heap_we, pos_re, pos_we;
  imhq_pkg::addr_t heap_raddr, heap_waddr, pos_waddr;
  imhq_pkg::elem_t pos_raddr;
  imhq_pkg::slot_t heap_wdata;

  imhq_pkg::cnt_t    capacity, cap_sat, count;
  imhq_pkg::addr_t   cur;
  imhq_pkg::slot_t   mv, ch;
  imhq_pkg::status_t res_status;
  imhq_pkg::key_t    res_time;
  imhq_pkg::elem_t   res_index;

  logic            accept, out_free;
  imhq_pkg::addr_t parent;
  imhq_pkg::idx_t  lidx, ridx;
  logic            l_in, r_in, right_win, sel_less, up_less, add_ok, upd_hit;
  imhq_pkg::slot_t sel;
  imhq_pkg::addr_t sel_idx;
  imhq_pkg::cnt_t  count_dec;

  assign in_ready  = (state == imhq_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cap_sat   = (capacity > imhq_pkg::CNT_W'(imhq_pkg::DEPTH)) ?
                     imhq_pkg::CNT_W'(imhq_pkg::DEPTH) : capacity;
  assign add_ok    = count < cap_sat;
  assign count_dec = count - 1'b1;
  assign parent    = imhq_pkg::ADDR_W'((cur - 1'b1) >> 1);
  assign lidx      = {1'b0, cur, 1'b1};
  assign ridx      = lidx + 1'b1;
  assign l_in      = lidx < imhq_pkg::IDX_W'(count);
  assign r_in      = ridx < imhq_pkg::IDX_W'(count);
  assign right_win = r_in && (heap_rd.key < ch.key);
  assign sel       = right_win ? heap_rd : ch;
  assign sel_idx   = right_win ? ridx[imhq_pkg::ADDR_W-1:0] : lidx[imhq_pkg::ADDR_W-1:0];
  assign sel_less  = sel.key < mv.key;
  assign up_less   = mv.key < heap_rd.key;
  assign upd_hit   = heap_rd.elem == mv.elem;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      imhq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (imhq_pkg::action_t'(action))
            imhq_pkg::ACT_ADD:    state_next = add_ok ? imhq_pkg::S_UP_RD : imhq_pkg::S_DONE;
            imhq_pkg::ACT_PULL:   state_next = (count == '0) ? imhq_pkg::S_DONE
                                                             : imhq_pkg::S_PULL_RT;
            imhq_pkg::ACT_UPDATE: state_next = imhq_pkg::S_UPD_POS;
            imhq_pkg::ACT_CLEAR:  state_next = imhq_pkg::S_DONE;
            default:              state_next = imhq_pkg::S_DONE;
          endcase
        end
      end
      imhq_pkg::S_UP_RD:   state_next = (cur == '0) ? imhq_pkg::S_PLACE : imhq_pkg::S_UP_CMP;
      imhq_pkg::S_UP_CMP:  state_next = up_less ? imhq_pkg::S_UP_RD : imhq_pkg::S_PLACE;
      imhq_pkg::S_PLACE:   state_next = imhq_pkg::S_DONE;
      imhq_pkg::S_PULL_RT: state_next = imhq_pkg::S_PULL_MV;
      imhq_pkg::S_PULL_MV: state_next = (count == '0) ? imhq_pkg::S_DONE : imhq_pkg::S_DN_L;
      imhq_pkg::S_UPD_POS: state_next = (imhq_pkg::CNT_W'(pos_rd) < count) ?
                                        imhq_pkg::S_UPD_SLOT : imhq_pkg::S_DONE;
      imhq_pkg::S_UPD_SLOT: begin
        priority if (!upd_hit)             state_next = imhq_pkg::S_DONE;
        else if (heap_rd.key < mv.key)     state_next = imhq_pkg::S_DN_L;
        else if (heap_rd.key > mv.key)     state_next = imhq_pkg::S_UP_RD;
        else                               state_next = imhq_pkg::S_PLACE;
      end
      imhq_pkg::S_DN_L:    state_next = l_in ? imhq_pkg::S_DN_R : imhq_pkg::S_PLACE;
      imhq_pkg::S_DN_R:    state_next = imhq_pkg::S_DN_CMP;
      imhq_pkg::S_DN_CMP:  state_next = sel_less ? imhq_pkg::S_DN_L : imhq_pkg::S_PLACE;
      imhq_pkg::S_DONE:    state_next = out_free ? imhq_pkg::S_IDLE : imhq_pkg::S_DONE;
      default:             state_next = imhq_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    heap_re    = 1'b0;
    heap_raddr = '0;
    pos_re     = 1'b0;
    pos_raddr  = elem_index;
    heap_we    = 1'b0;
    heap_waddr = cur;
    heap_wdata = mv;
    pos_we     = 1'b0;
    pos_waddr  = cur;
    unique case (state)
      imhq_pkg::S_IDLE: begin
        if (accept && imhq_pkg::action_t'(action) == imhq_pkg::ACT_PULL) begin
          heap_re = 1'b1;
        end
        if (accept && imhq_pkg::action_t'(action) == imhq_pkg::ACT_UPDATE) begin
          pos_re = 1'b1;
        end
      end
      imhq_pkg::S_UP_RD: begin
        heap_re    = 1'b1;
        heap_raddr = parent;
      end
      imhq_pkg::S_UP_CMP: begin
        // parent drops into the hole
        heap_we    = up_less;
        heap_wdata = heap_rd;
        pos_we     = up_less;
      end
      imhq_pkg::S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      imhq_pkg::S_PULL_RT: begin
        heap_re    = 1'b1;
        heap_raddr = count_dec[imhq_pkg::ADDR_W-1:0];
      end
      imhq_pkg::S_UPD_POS: begin
        heap_re    = 1'b1;
        heap_raddr = pos_rd;
      end
      imhq_pkg::S_DN_L: begin
        heap_re    = l_in;
        heap_raddr = lidx[imhq_pkg::ADDR_W-1:0];
      end
      imhq_pkg::S_DN_R: begin
        heap_re    = r_in;
        heap_raddr = ridx[imhq_pkg::ADDR_W-1:0];
      end
      imhq_pkg::S_DN_CMP: begin
        // smaller child rises into the hole
        heap_we    = sel_less;
        heap_wdata = sel;
        pos_we     = sel_less;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_rd <= heap_mem[heap_raddr];
    end
    if (pos_we) begin
      pos_mem[heap_wdata.elem] <= pos_waddr;
    end
    if (pos_re) begin
      pos_rd <= pos_mem[pos_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imhq_pkg::S_IDLE;
      count     <= '0;
      capacity  <= imhq_pkg::CNT_W'(imhq_pkg::DEPTH);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept && imhq_pkg::action_t'(action) == imhq_pkg::ACT_ADD && add_ok) begin
        count <= count + 1'b1;
      end
      if (accept && imhq_pkg::action_t'(action) == imhq_pkg::ACT_CLEAR) begin
        count <= '0;
      end
      if (state == imhq_pkg::S_PULL_RT) begin
        count <= count_dec;
      end
      if (state == imhq_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mv         <= '{key: key_time, elem: elem_index};
      cur        <= count[imhq_pkg::ADDR_W-1:0];
      res_time   <= '0;
      res_index  <= '0;
      res_status <= imhq_pkg::ST_OK;
      if (imhq_pkg::action_t'(action) == imhq_pkg::ACT_ADD && !add_ok) begin
        res_status <= imhq_pkg::ST_FULL;
      end
      if (imhq_pkg::action_t'(action) == imhq_pkg::ACT_PULL && count == '0) begin
        res_status <= imhq_pkg::ST_EMPTY;
      end
    end
    unique case (state)
      imhq_pkg::S_UP_CMP: if (up_less) cur <= parent;
      imhq_pkg::S_PULL_RT: begin
        res_time  <= heap_rd.key;
        res_index <= heap_rd.elem;
      end
      imhq_pkg::S_PULL_MV: begin
        mv  <= heap_rd;
        cur <= '0;
      end
      imhq_pkg::S_UPD_POS:  cur <= pos_rd;
      imhq_pkg::S_DN_R:     ch  <= heap_rd;
      imhq_pkg::S_DN_CMP:   if (sel_less) cur <= sel_idx;
      imhq_pkg::S_DONE: begin
        if (out_free) begin
          status     <= res_status;
          out_time   <= res_time;
          out_index  <= res_index;
          fill_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= imhq_pkg::CNT_W'(imhq_pkg::DEPTH))
    else $error("entry count above depth");

  a_ram_pair: assert property (@(posedge clk) disable iff (rst)
    heap_we == pos_we)
    else $error("slot and position writes out of step");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second word taken while busy");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && imhq_pkg::action_t'(action) == imhq_pkg::ACT_ADD && !add_ok)
      |=> $stable(count))
    else $error("full add changed fill count");

endmodule

`default_nettype wire

### bench/indexed_min_heap_queue_top_test.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top_test: self-checking bench for the heap queue
// Drives add / pull / update / clear words, predicts every result with a
// behavioral heap and compares each output word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_min_heap_queue_top_test;

  localparam int HEAP_SLOTS = 1024;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  imhq_pkg::elem_t elem_index = '0;
  imhq_pkg::key_t key_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  imhq_pkg::key_t out_time;
  imhq_pkg::elem_t out_index;
  imhq_pkg::cnt_t fill_count;
  logic cfg_we = 1'b0;
  imhq_pkg::cnt_t cfg_wdata = '0;

  indexed_min_heap_queue_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .elem_index(elem_index), .key_time(key_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_time(out_time), .out_index(out_index),
    .fill_count(fill_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [1:0] st;
    imhq_pkg::key_t tm;
    imhq_pkg::elem_t ix;
    imhq_pkg::cnt_t fill;
  } heap_result_t;

  // behavioral heap
  imhq_pkg::key_t hk[HEAP_SLOTS];
  imhq_pkg::elem_t he[HEAP_SLOTS];
  int unsigned hpos[HEAP_SLOTS];
  int unsigned hcount;
  int unsigned hcap;
  logic written[HEAP_SLOTS];   // element ever added

  heap_result_t pending[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit timed_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;

  function automatic void heap_swap(int unsigned a, int unsigned b);
    imhq_pkg::key_t k;
    imhq_pkg::elem_t e;
    k = hk[a]; e = he[a];
    hk[a] = hk[b]; he[a] = he[b];
    hk[b] = k; he[b] = e;
    hpos[he[a]] = a;
    hpos[he[b]] = b;
  endfunction

  function automatic void heap_raise(int unsigned at);
    int unsigned up;
    while (at > 0) begin
      up = (at - 1) >> 1;
      if (hk[at] < hk[up]) begin
        heap_swap(at, up);
        at = up;
      end else break;
    end
  endfunction

  function automatic void heap_sink(int unsigned at);
    int unsigned l, r, m;
    forever begin
      l = 2 * at + 1;
      r = l + 1;
      if (l >= hcount) break;
      m = l;
      if (r < hcount && hk[r] < hk[l]) m = r;
      if (hk[m] < hk[at]) begin
        heap_swap(at, m);
        at = m;
      end else break;
    end
  endfunction

  function automatic heap_result_t heap_apply(logic [1:0] act, imhq_pkg::elem_t el,
                                              imhq_pkg::key_t k);
    heap_result_t r;
    int unsigned cap, s;
    imhq_pkg::key_t old;
    cap = hcap > HEAP_SLOTS ? HEAP_SLOTS : hcap;
    r.st = imhq_pkg::ST_OK; r.tm = '0; r.ix = '0;
    case (act)
      imhq_pkg::ACT_ADD: begin
        if (hcount < cap) begin
          s = hcount;
          hk[s] = k; he[s] = el; hpos[el] = s;
          written[el] = 1'b1;
          hcount = s + 1;
          heap_raise(s);
        end else r.st = imhq_pkg::ST_FULL;
      end
      imhq_pkg::ACT_PULL: begin
        if (hcount == 0) r.st = imhq_pkg::ST_EMPTY;
        else begin
          r.tm = hk[0]; r.ix = he[0];
          hcount--;
          if (hcount > 0) begin
            hk[0] = hk[hcount]; he[0] = he[hcount];
            hpos[he[0]] = 0;
            heap_sink(0);
          end
        end
      end
      imhq_pkg::ACT_UPDATE: begin
        s = hpos[el];
        if (written[el] && s < hcount && he[s] == el) begin
          old = hk[s];
          hk[s] = k;
          if (old < k) heap_sink(s);
          else if (old > k) heap_raise(s);
        end
      end
      default: hcount = 0;
    endcase
    r.fill = imhq_pkg::cnt_t'(hcount);
    return r;
  endfunction

  // an update never reads a position entry that was never written
  function automatic imhq_pkg::elem_t pick_update_elem();
    imhq_pkg::elem_t e;
    if (hcount > 0 && $urandom_range(0, 3) != 0) return he[$urandom_range(0, hcount - 1)];
    repeat (8) begin
      e = imhq_pkg::elem_t'($urandom);
      if (written[e]) return e;
    end
    return hcount > 0 ? he[0] : imhq_pkg::elem_t'(0);
  endfunction

  task automatic send_word(logic [1:0] act, imhq_pkg::elem_t el, imhq_pkg::key_t k);
    logic [1:0] a;
    imhq_pkg::elem_t e;
    a = act; e = el;
    if (a == imhq_pkg::ACT_UPDATE && !written[e]) begin
      if (hcount == 0 && !written[0]) a = imhq_pkg::ACT_PULL;
      else e = pick_update_elem();
      if (!written[e]) a = imhq_pkg::ACT_PULL;
    end
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    action <= a; elem_index <= e; key_time <= k; in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(heap_apply(a, e, k));
    in_valid <= 1'b0;
    // block is busy for at least this edge anyway
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned c);
    drain();
    cfg_wdata <= imhq_pkg::cnt_t'(c); cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    hcap = c & 11'h7FF;
  endtask

  function automatic imhq_pkg::key_t rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return imhq_pkg::key_t'($urandom_range(0, 15));
      default: return imhq_pkg::key_t'($urandom);
    endcase
  endfunction

  task automatic random_words(int n);
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 45) send_word(imhq_pkg::ACT_ADD, imhq_pkg::elem_t'($urandom), rand_key());
      else if (p < 75)
        send_word(imhq_pkg::ACT_PULL, imhq_pkg::elem_t'($urandom), imhq_pkg::key_t'($urandom));
      else if (p < 97) send_word(imhq_pkg::ACT_UPDATE, pick_update_elem(), rand_key());
      else
        send_word(imhq_pkg::ACT_CLEAR, imhq_pkg::elem_t'($urandom), imhq_pkg::key_t'($urandom));
    end
  endtask

  task automatic test_directed();
    send_word(imhq_pkg::ACT_PULL, '0, '0);
    send_word(imhq_pkg::ACT_ADD, 10'h3FF, '1);
    send_word(imhq_pkg::ACT_ADD, 10'h000, '0);
    send_word(imhq_pkg::ACT_ADD, 10'h155, 32'h0001_8000);
    send_word(imhq_pkg::ACT_ADD, 10'h2AA, 32'h0001_8000);
    send_word(imhq_pkg::ACT_ADD, 10'h155, 32'h0000_0005);  // duplicate element
    send_word(imhq_pkg::ACT_UPDATE, 10'h3FF, 32'h0000_0001);
    send_word(imhq_pkg::ACT_UPDATE, 10'h2AA, 32'hFFFF_0000);
    send_word(imhq_pkg::ACT_UPDATE, 10'h000, 32'h0000_0000); // equal key
    send_word(imhq_pkg::ACT_PULL, '1, '1);
    send_word(imhq_pkg::ACT_UPDATE, 10'h3FF, 32'h0000_0001); // may be stale
    repeat (5) send_word(imhq_pkg::ACT_PULL, '0, '0);
    send_word(imhq_pkg::ACT_ADD, 10'h001, 32'h5555_AAAA);
    send_word(imhq_pkg::ACT_CLEAR, '1, '1);
    send_word(imhq_pkg::ACT_UPDATE, 10'h001, 32'h0);         // not held after clear
    send_word(imhq_pkg::ACT_PULL, '0, '0);
  endtask

  task automatic test_capacity();
    set_capacity(0);
    send_word(imhq_pkg::ACT_ADD, 10'h3, 32'h7);
    send_word(imhq_pkg::ACT_PULL, '0, '0);
    set_capacity(3);
    repeat (5) send_word(imhq_pkg::ACT_ADD, imhq_pkg::elem_t'($urandom), rand_key());
    set_capacity(1);                               // below fill
    send_word(imhq_pkg::ACT_ADD, 10'h9, 32'h1);
    send_word(imhq_pkg::ACT_PULL, '0, '0);
    set_capacity(2047);                            // saturates
    random_words(150);
    set_capacity(5);
    random_words(100);
    set_capacity(1024);
  endtask

  task automatic test_fill_up();
    // long receiver hold-off while words keep coming
    hold_recv = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      random_words(60);
    join
    drain();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0; recv_stall_pct = 0;  random_words(250);
    drain();                                // sender pause until all results are in
    send_idle_pct = 53; recv_stall_pct = 0; random_words(200);
    send_idle_pct = 0; recv_stall_pct = 53; random_words(200);
    send_idle_pct = 22; recv_stall_pct = 22; random_words(200);
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    heap_result_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: status %0d", status);
      end else begin
        x = pending.pop_front();
        if (status !== x.st || out_time !== x.tm || out_index !== x.ix ||
            fill_count !== x.fill) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d tm %h ix %0d fill %0d,",
                      " got st %0d tm %h ix %0d fill %0d"},
                     x.st, x.tm, x.ix, x.fill, status, out_time, out_index, fill_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_recv ||
        (!in_valid && pending.size() == 0))
      stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    hcount = 0;
    hcap = 1024;
    foreach (written[i]) written[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_fill_up();
    test_random_phases();
    drain();
    if (mismatches == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### indexed_min_heap_queue_top.f
rtl/core/imhq_pkg.sv
rtl/core/indexed_min_heap_queue_top.sv
bench/indexed_min_heap_queue_top_test.sv
